// ===== rtl/core/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and constants for the indexed list insert/remove core.
// ----------------------------------------------------------------------------
package ilir_pkg;

    // store geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SET    = 2'd2,
        OP_GET    = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // broadcast control from the control block (ilir_ctrl) to every cell
    typedef struct packed {
        logic                     shift_up;
        logic                     shift_dn;
        logic                     wr;
        logic [POS_W-1:0]         pos;
        logic [IDX_W-1:0]         rd_pos;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

// ===== rtl/core/ilir_cell.sv =====
// ----------------------------------------------------------------------------
// ilir_cell
// One list slot: holds an entry and takes its own value, the neighbor below,
// the neighbor above or the broadcast word, as the control asks.
// ----------------------------------------------------------------------------
module ilir_cell (
    input  logic                             i_clk,
    input  logic [ilir_pkg::IDX_W-1:0]       i_idx,
    input  ilir_pkg::t_cell_ctl              i_ctl,
    input  logic signed [ilir_pkg::DATA_W-1:0] i_left,
    input  logic signed [ilir_pkg::DATA_W-1:0] i_right,
    output logic signed [ilir_pkg::DATA_W-1:0] o_data,
    output logic signed [ilir_pkg::DATA_W-1:0] o_rd
);
    import ilir_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic [POS_W-1:0]         w_idx;
    logic                     w_at;
    logic                     w_above;

    assign w_idx   = POS_W'(i_idx);
    assign w_at    = (w_idx == i_ctl.pos);
    assign w_above = (w_idx > i_ctl.pos);

    // next entry selection
    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_up) begin
            if (w_at) begin
                n_data = i_ctl.value;
            end else if (w_above) begin
                n_data = i_left;
            end
        end else if (i_ctl.shift_dn) begin
            if (w_at || w_above) begin
                n_data = i_right;
            end
        end else if (i_ctl.wr && w_at) begin
            n_data = i_ctl.value;
        end
    end

    // entry register
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // read port: only the addressed cell drives a nonzero word
    assign o_rd   = (i_idx == i_ctl.rd_pos) ? r_data : '0;

endmodule

// ===== rtl/core/ilir_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilir_ctrl
// Live count and operation decode: checks range and fullness, drives the
// cell control and forms the status and count of each result.
// ----------------------------------------------------------------------------
module ilir_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [1:0]                    i_op,
    input  logic [ilir_pkg::POS_W-1:0]    i_pos,
    input  logic signed [ilir_pkg::DATA_W-1:0] i_value,
    output ilir_pkg::t_cell_ctl           o_ctl,
    output ilir_pkg::t_status             o_status,
    output logic                          o_is_get,
    output logic [ilir_pkg::CNT_W-1:0]    o_count
);
    import ilir_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_op              w_op;
    logic             w_full;
    logic             w_in_rng;
    logic             w_ins_rng;

    assign w_op      = t_op'(i_op);
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_in_rng  = (POS_W'(r_count) > i_pos);
    assign w_ins_rng = (POS_W'(r_count) >= i_pos);

    // decode and status
    always_comb begin
        o_ctl          = '0;
        o_ctl.pos      = i_pos;
        o_ctl.value    = i_value;
        o_ctl.rd_pos   = w_in_rng ? i_pos[IDX_W-1:0] : '0;
        o_status       = ST_OK;
        o_is_get       = 1'b0;
        n_count        = r_count;
        case (w_op)
            OP_INSERT: begin
                if (w_full) begin
                    o_status = ST_FULL;
                end else if (!w_ins_rng) begin
                    o_status = ST_RANGE;
                end else begin
                    o_ctl.shift_up = i_fire;
                    n_count        = r_count + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!w_in_rng) begin
                    o_status = ST_RANGE;
                end else begin
                    // removing the last remaining entry only drops the count,
                    // so entry 0 keeps its word
                    o_ctl.shift_dn = i_fire && (r_count != CNT_W'(1));
                    n_count        = r_count - 1'b1;
                end
            end
            OP_SET: begin
                if (!w_in_rng) begin
                    o_status = ST_RANGE;
                end else begin
                    o_ctl.wr = i_fire;
                end
            end
            default: begin
                o_is_get = 1'b1;
                if (!w_in_rng) begin
                    o_status = ST_RANGE;
                end
            end
        endcase
    end

    // live count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    assign o_count = n_count;

endmodule

// ===== rtl/core/indexed_list_insert_remove_core.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_core
// Ordered list of signed words held in a row of cells; insert and remove
// shift every later entry by one slot in one parallel update.
//
//   channel | direction | handshake                 | beat fields
//   --------+-----------+---------------------------+--------------------------
//   in      | sink      | i_in_valid / o_in_stall   | i_op, i_pos, i_value
//   out     | source    | o_out_valid / i_out_stall | o_read_value, o_status,
//           |           |                           | o_count
//
// Every operation finishes in one parallel update: all cells update from
// their neighbors, so one beat is taken per clock while the result register
// drains. The registered result appears in the cycle after the beat is accepted.
// Reset empties the list and the result register; entries are not cleared.
// A stalled result holds the input off until it is taken.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_op,
    input  logic [ilir_pkg::POS_W-1:0]         i_pos,
    input  logic signed [ilir_pkg::DATA_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [ilir_pkg::DATA_W-1:0] o_read_value,
    output logic [1:0]                         o_status,
    output logic [ilir_pkg::CNT_W-1:0]         o_count
);
    import ilir_pkg::*;

    logic                     w_fire;
    t_cell_ctl                w_ctl;
    t_status                  w_status;
    logic                     w_is_get;
    logic [CNT_W-1:0]         w_count;
    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic signed [DATA_W-1:0] w_rd   [CAPACITY];
    logic signed [DATA_W-1:0] w_rd_or;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_read_value;
    t_status                  r_status;
    logic [CNT_W-1:0]         r_count;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_fire     = i_in_valid && !o_in_stall;

    // decode and live count
    ilir_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_op     (i_op),
        .i_pos    (i_pos),
        .i_value  (i_value),
        .o_ctl    (w_ctl),
        .o_status (w_status),
        .o_is_get (w_is_get),
        .o_count  (w_count)
    );

    // row of cells, each linked to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ilir_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_data[(g == 0) ? 0 : g - 1]),
            .i_right (w_data[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data  (w_data[g]),
            .o_rd    (w_rd[g])
        );
    end

    // read collection: at most one cell is nonzero
    always_comb begin
        w_rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_or = w_rd_or | w_rd[k];
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_read_value <= w_is_get ? w_rd_or : '0;
            r_status     <= w_status;
            r_count      <= w_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = r_count;

    // count never passes the store size
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_count <= CNT_W'(CAPACITY)))
        else $error("count above capacity");

    // a full status only when the store is full
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_count == CNT_W'(CAPACITY)))
        else $error("full status with free slots");

    // an accepted beat always yields a result next cycle
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("accepted beat lost");

endmodule
